### rtl/mpcs_pkg.sv
package mpcs_pkg;

  // Duty word width of the request and status fields
  localparam int DUTY_BITS = 16;

  localparam int CMP_W      = 15;
  localparam int TRIM_W     = 11;
  localparam int MASK_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Magnitude fed to the trim multiplier saturates here; any larger value
  // already scales past every possible clamp limit for nonzero trim.
  localparam int MAG_W   = 25;
  localparam int MAG_LIM = (1 << MAG_W) - 1;
  localparam int PROD_W  = MAG_W + TRIM_W;
  localparam int EXT_W   = ((DUTY_BITS > MAG_W) ? DUTY_BITS : MAG_W) + 2;
  localparam int QUOT_W  = CMP_W + 1;

  // Rounded divide by the trim unit through a reciprocal multiply
  localparam int TRIM_UNITY    = 1000;
  localparam int ROUND_HALF    = TRIM_UNITY / 2;
  localparam int DIV_SAT       = (1 << CMP_W) * TRIM_UNITY;
  localparam int DIV_W         = $clog2(DIV_SAT);
  localparam int DIV_PRE_SHIFT = 3;
  localparam int DIV_ODD       = TRIM_UNITY >> DIV_PRE_SHIFT;
  localparam int DIV_IN_W      = DIV_W - DIV_PRE_SHIFT;
  localparam int RECIP_SHIFT   = DIV_IN_W + $clog2(DIV_ODD);
  localparam int RECIP         = ((1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
  localparam int RECIP_W       = $clog2(RECIP + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TRIM   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TRIM  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_MASK   = CFG_IDX_W'(6);

  // Wheel ids
  localparam logic [7:0] ID_LEFT_A = 8'd0;
  localparam logic [7:0] ID_LEFT_B = 8'd1;
  localparam logic [7:0] ID_RIGHT  = 8'd2;

  // Reset values
  localparam logic [CMP_W-1:0]  RST_DEADBAND    = '0;
  localparam logic [CMP_W-1:0]  RST_FEEDFORWARD = '0;
  localparam logic [CMP_W-1:0]  RST_MAX_DUTY    = '1;
  localparam logic [TRIM_W-1:0] RST_TRIM        = TRIM_W'(TRIM_UNITY);
  localparam logic [MASK_W-1:0] RST_INVERT_MASK = '0;
  localparam logic [MASK_W-1:0] RST_PAIR_MASK   = MASK_W'(2);

  typedef struct packed {
    logic [CMP_W-1:0]  deadband;
    logic [CMP_W-1:0]  feedforward;
    logic [CMP_W-1:0]  max_duty;
    logic [TRIM_W-1:0] left_trim;
    logic [TRIM_W-1:0] right_trim;
    logic [MASK_W-1:0] invert_mask;
    logic [MASK_W-1:0] pair_mask;
  } cfg_t;

endpackage

### rtl/mpcs_cfg.sv
module mpcs_cfg
  import mpcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DEADBAND:    cfg_nxt.deadband    = cfg_data[CMP_W-1:0];
        REG_FEEDFORWARD: cfg_nxt.feedforward = cfg_data[CMP_W-1:0];
        REG_MAX_DUTY:    cfg_nxt.max_duty    = cfg_data[CMP_W-1:0];
        REG_LEFT_TRIM:   cfg_nxt.left_trim   = cfg_data[TRIM_W-1:0];
        REG_RIGHT_TRIM:  cfg_nxt.right_trim  = cfg_data[TRIM_W-1:0];
        REG_INVERT_MASK: cfg_nxt.invert_mask = cfg_data[MASK_W-1:0];
        REG_PAIR_MASK:   cfg_nxt.pair_mask   = cfg_data[MASK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband    <= RST_DEADBAND;
      cfg_r.feedforward <= RST_FEEDFORWARD;
      cfg_r.max_duty    <= RST_MAX_DUTY;
      cfg_r.left_trim   <= RST_TRIM;
      cfg_r.right_trim  <= RST_TRIM;
      cfg_r.invert_mask <= RST_INVERT_MASK;
      cfg_r.pair_mask   <= RST_PAIR_MASK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/mpcs_div1000.sv
module mpcs_div1000
  import mpcs_pkg::*;
(
  input  logic [PROD_W-1:0] prod_i,
  output logic [QUOT_W-1:0] quot_o
);

  logic [PROD_W:0]                 sum;
  logic [DIV_IN_W-1:0]             pre;
  logic [DIV_IN_W+RECIP_W-1:0]     mul;

  // Round half up, then divide: strip the power of two, multiply by the
  // reciprocal of the odd part. Sums past the saturation point are above
  // every clamp limit anyway.
  assign sum = {1'b0, prod_i} + (PROD_W+1)'(ROUND_HALF);
  assign pre = sum[DIV_W-1:DIV_PRE_SHIFT];
  assign mul = (DIV_IN_W+RECIP_W)'(pre) * (DIV_IN_W+RECIP_W)'(RECIP);

  assign quot_o = (sum >= (PROD_W+1)'(DIV_SAT)) ? QUOT_W'(1 << CMP_W)
                                                 : mul[RECIP_SHIFT +: QUOT_W];

endmodule

### rtl/motor_pwm_command_shaper.sv
// An accepted transaction passes the s1, s2, s3 and output registers to out_valid.
// Throughput: one transaction per cycle unless out_ready stalls the pipeline; the
// trim multiply and the reciprocal divide multiply each own a pipeline stage.
// Requests with an unknown motor id are accepted and dropped at the input stage.
// Reset: stage valid bits clear, configuration registers load their defaults.
module motor_pwm_command_shaper
  import mpcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [7:0]            in_motor_id,
  input  logic [DUTY_BITS-1:0]  in_duty_request,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_wheel,
  output logic                  out_upper_pair,
  output logic [CMP_W-1:0]      out_forward_compare,
  output logic [CMP_W-1:0]      out_reverse_compare,
  output logic [DUTY_BITS-1:0]  out_logical_duty
);

  cfg_t cfg;

  mpcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Stage enables
  logic out_en, s3_en, s2_en, s1_en;

  logic                 s1_valid_r, s1_raw_r, s1_wheel_r;
  logic [DUTY_BITS-1:0] s1_duty_r;
  logic                 s2_valid_r, s2_wheel_r, s2_neg_r;
  logic [PROD_W-1:0]    s2_prod_r;
  logic                 s3_valid_r, s3_wheel_r, s3_neg_r;
  logic [QUOT_W-1:0]    s3_quot_r;
  logic                 out_valid_r, out_wheel_r, out_upper_r;
  logic [CMP_W-1:0]     out_fwd_r, out_rev_r;
  logic [DUTY_BITS-1:0] out_logical_r;

  logic                 s1_valid_nxt, s1_wheel_nxt;
  logic                 s2_neg_nxt;
  logic [PROD_W-1:0]    s2_prod_nxt;
  logic [QUOT_W-1:0]    s3_quot_nxt;
  logic                 out_upper_nxt;
  logic [CMP_W-1:0]     out_fwd_nxt, out_rev_nxt;
  logic [DUTY_BITS-1:0] out_logical_nxt;

  assign out_en   = !out_valid_r || out_ready;
  assign s3_en    = !s3_valid_r || out_en;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  // Input decode: drop unknown ids
  assign s1_valid_nxt = in_valid && (in_motor_id == ID_LEFT_A || in_motor_id == ID_LEFT_B ||
                                     in_motor_id == ID_RIGHT);
  assign s1_wheel_nxt = (in_motor_id == ID_RIGHT);

  // Stage 1: deadband, feedforward, first clamp (all skipped for raw commands), magnitude times trim
  logic signed [EXT_W-1:0] v_ext, db_s, ff_s, max_s, shaped;
  logic        [EXT_W-1:0] mag;
  logic        [MAG_W-1:0] mag_sat;
  logic       [TRIM_W-1:0] trim;

  assign v_ext = {{(EXT_W-DUTY_BITS){s1_duty_r[DUTY_BITS-1]}}, s1_duty_r};
  assign db_s  = {{(EXT_W-CMP_W){1'b0}}, cfg.deadband};
  assign ff_s  = {{(EXT_W-CMP_W){1'b0}}, cfg.feedforward};
  assign max_s = {{(EXT_W-CMP_W){1'b0}}, cfg.max_duty};
  assign trim  = s1_wheel_r ? cfg.right_trim : cfg.left_trim;

  always_comb begin
    shaped = v_ext;
    if (!s1_raw_r) begin
      if (v_ext > db_s) begin
        shaped = v_ext + ff_s;
      end else if (v_ext < -db_s) begin
        shaped = v_ext - ff_s;
      end else begin
        shaped = '0;
      end
      if (shaped > max_s) begin
        shaped = max_s;
      end else if (shaped < -max_s) begin
        shaped = -max_s;
      end
    end
  end

  assign s2_neg_nxt  = shaped[EXT_W-1];
  assign mag         = s2_neg_nxt ? -shaped : shaped;
  assign mag_sat     = (mag > EXT_W'(MAG_LIM)) ? MAG_W'(MAG_LIM) : mag[MAG_W-1:0];
  assign s2_prod_nxt = PROD_W'(mag_sat) * PROD_W'(trim);

  // Stage 2: rounded divide by the trim unit
  mpcs_div1000 u_div (
    .prod_i (s2_prod_r),
    .quot_o (s3_quot_nxt)
  );

  // Stage 3: second clamp, direction inversion, channel select
  logic [CMP_W-1:0] duty_clamped;
  logic [EXT_W-1:0] logical_ext;
  logic             hw_reverse;

  assign duty_clamped = (s3_quot_r > QUOT_W'(cfg.max_duty)) ? cfg.max_duty
                                                             : s3_quot_r[CMP_W-1:0];
  assign logical_ext  = s3_neg_r ? -EXT_W'(duty_clamped) : EXT_W'(duty_clamped);
  assign hw_reverse   = s3_neg_r ^ cfg.invert_mask[s3_wheel_r];

  assign out_logical_nxt = logical_ext[DUTY_BITS-1:0];
  assign out_fwd_nxt     = hw_reverse ? '0 : duty_clamped;
  assign out_rev_nxt     = hw_reverse ? duty_clamped : '0;
  assign out_upper_nxt   = cfg.pair_mask[s3_wheel_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= s1_valid_nxt;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_en) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_en) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_raw_r   <= in_cmd;
      s1_wheel_r <= s1_wheel_nxt;
      s1_duty_r  <= in_duty_request;
    end
    if (s2_en) begin
      s2_wheel_r <= s1_wheel_r;
      s2_neg_r   <= s2_neg_nxt;
      s2_prod_r  <= s2_prod_nxt;
    end
    if (s3_en) begin
      s3_wheel_r <= s2_wheel_r;
      s3_neg_r   <= s2_neg_r;
      s3_quot_r  <= s3_quot_nxt;
    end
    if (out_en) begin
      out_wheel_r   <= s3_wheel_r;
      out_upper_r   <= out_upper_nxt;
      out_fwd_r     <= out_fwd_nxt;
      out_rev_r     <= out_rev_nxt;
      out_logical_r <= out_logical_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_wheel           = out_wheel_r;
  assign out_upper_pair      = out_upper_r;
  assign out_forward_compare = out_fwd_r;
  assign out_reverse_compare = out_rev_r;
  assign out_logical_duty    = out_logical_r;

`ifndef SYNTH
  a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fwd_r == '0 || out_rev_r == '0))
    else $error("both channels of the pair driven");

  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fwd_r <= cfg.max_duty && out_rev_r <= cfg.max_duty))
    else $error("compare value above max duty");

  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(in_motor_id == ID_LEFT_A || in_motor_id == ID_LEFT_B ||
                               in_motor_id == ID_RIGHT)) |=> !s1_valid_r)
    else $error("unknown motor id entered the pipeline");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && out_valid_r && !out_ready) |=> (s3_valid_r && $stable(s3_quot_r)))
    else $error("stage 3 lost its transaction under backpressure");
`endif

endmodule
